// ===== sv/dsds_pkg.sv =====
// ----------------------------------------------------------------------------
// dsds_pkg
// Character codes and shared types for the significant digit span block.
// ----------------------------------------------------------------------------
package dsds_pkg;

    // character codes seen by the parser
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_E_LO  = 8'h65;

    // width of the digit place fields of a result
    localparam int unsigned PLACE_W = 15;

    // summary flags of a finished string, parser to top level
    typedef struct packed {
        logic ok;         // text is a valid number
        logic has_digit;  // a nonzero significand digit was seen
        logic exp_neg;    // exponent carries a minus sign
    } fin_flags_t;

endpackage

// ===== sv/dsds_char_if.sv =====
// ----------------------------------------------------------------------------
// dsds_char_if
// Character channel: one text character per transfer.
// ----------------------------------------------------------------------------
interface dsds_char_if;

    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;
    logic       empty_string;

    modport source (output valid, output char_code, output last_char,
                    output empty_string, input ready);
    modport sink   (input valid, input char_code, input last_char,
                    input empty_string, output ready);

endinterface

// ===== sv/dsds_res_if.sv =====
// ----------------------------------------------------------------------------
// dsds_res_if
// Result channel: validity and digit places of one finished string.
// ----------------------------------------------------------------------------
interface dsds_res_if;

    logic                            valid;
    logic                            ready;
    logic                            valid_res;
    logic signed [dsds_pkg::PLACE_W-1:0] largest_digit;
    logic signed [dsds_pkg::PLACE_W-1:0] smallest_digit;

    modport source (output valid, output valid_res, output largest_digit,
                    output smallest_digit, input ready);
    modport sink   (input valid, input valid_res, input largest_digit,
                    input smallest_digit, output ready);

endinterface

// ===== sv/dsds_parser.sv =====
// ----------------------------------------------------------------------------
// dsds_parser
// Running parse state of one number text; updated once per taken character,
// presents the summary of the string as it stands after that character.
// ----------------------------------------------------------------------------
module dsds_parser #(
    parameter int MAX_CHARS      = 64,
    parameter int EXPONENT_LIMIT = 9999,
    parameter int EW             = $clog2(EXPONENT_LIMIT + 1),
    parameter int PW             = $clog2(MAX_CHARS + 1) + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [7:0]                  char_code,
    input  logic                        empty_string,
    input  logic                        item_ends,
    output dsds_pkg::fin_flags_t        fin_flags,
    output logic [EW-1:0]               fin_exp,
    output logic signed [PW-1:0]        fin_top,
    output logic signed [PW-1:0]        fin_bot
);

    localparam int CPW = $clog2(MAX_CHARS + 1);
    localparam int VW  = EW + 4;

    logic [CPW-1:0]       char_pos_reg, char_pos_next, char_pos_upd;
    logic                 over_reg, over_next, over_upd;
    logic                 in_exp_reg, in_exp_next, in_exp_upd;
    logic                 exp_neg_reg, exp_neg_next, exp_neg_upd;
    logic [EW-1:0]        exp_val_reg, exp_val_next, exp_val_upd;
    logic                 exp_dig_reg, exp_dig_next, exp_dig_upd;
    logic                 exp_any_reg, exp_any_next, exp_any_upd;
    logic                 fail_reg, fail_next, fail_upd;
    logic                 dot_reg, dot_next, dot_upd;
    logic                 nz_reg, nz_next, nz_upd;
    logic                 zs_reg, zs_next, zs_upd;
    logic signed [PW-1:0] top_reg, top_next, top_upd;
    logic signed [PW-1:0] bot_reg, bot_next, bot_upd;
    logic signed [PW-1:0] frac_reg, frac_next, frac_upd;

    logic                 is_digit;
    logic [VW-1:0]        exp_mac;
    logic signed [PW-1:0] frac_dec;

    // exponent accumulate: value * 10 + digit, saturated
    assign is_digit = (char_code inside {[dsds_pkg::CH_ZERO:dsds_pkg::CH_NINE]});
    assign exp_mac  = VW'({exp_val_reg, 3'b000}) + VW'({exp_val_reg, 1'b0})
                    + VW'(char_code[3:0]);
    assign frac_dec = frac_reg - PW'(1);

    // effect of one character on the parse state
    always_comb
    begin
        char_pos_upd = char_pos_reg;
        over_upd     = over_reg;
        in_exp_upd   = in_exp_reg;
        exp_neg_upd  = exp_neg_reg;
        exp_val_upd  = exp_val_reg;
        exp_dig_upd  = exp_dig_reg;
        exp_any_upd  = exp_any_reg;
        fail_upd     = fail_reg;
        dot_upd      = dot_reg;
        nz_upd       = nz_reg;
        zs_upd       = zs_reg;
        top_upd      = top_reg;
        bot_upd      = bot_reg;
        frac_upd     = frac_reg;
        if (!empty_string && !over_reg)
        begin
            if (char_pos_reg >= CPW'(MAX_CHARS))
            begin
                over_upd = 1'b1;
            end
            else
            begin
                char_pos_upd = char_pos_reg + CPW'(1);
                if (in_exp_reg)
                begin
                    // exponent part
                    exp_any_upd = 1'b1;
                    if (!exp_any_reg && (char_code == dsds_pkg::CH_PLUS ||
                                         char_code == dsds_pkg::CH_MINUS))
                    begin
                        exp_neg_upd = (char_code == dsds_pkg::CH_MINUS);
                    end
                    else if (is_digit)
                    begin
                        exp_dig_upd = 1'b1;
                        if (exp_mac > VW'(EXPONENT_LIMIT))
                            exp_val_upd = EW'(EXPONENT_LIMIT);
                        else
                            exp_val_upd = exp_mac[EW-1:0];
                    end
                    else
                    begin
                        fail_upd = 1'b1;
                    end
                end
                else if (char_code == dsds_pkg::CH_E_LO || char_code == dsds_pkg::CH_E_UP)
                begin
                    in_exp_upd = 1'b1;
                end
                else if (char_code == dsds_pkg::CH_PLUS || char_code == dsds_pkg::CH_MINUS)
                begin
                    // sign only as the first character
                    if (char_pos_reg != '0)
                        fail_upd = 1'b1;
                end
                else if (char_code == dsds_pkg::CH_ZERO)
                begin
                    zs_upd = 1'b1;
                    if (dot_reg)
                    begin
                        frac_upd = frac_dec;
                    end
                    else if (nz_reg)
                    begin
                        top_upd = top_reg + PW'(1);
                        bot_upd = bot_reg + PW'(1);
                    end
                end
                else if (char_code inside {[dsds_pkg::CH_ONE:dsds_pkg::CH_NINE]})
                begin
                    nz_upd = 1'b1;
                    if (dot_reg)
                    begin
                        frac_upd = frac_dec;
                        bot_upd  = frac_dec;
                        if (!nz_reg)
                            top_upd = frac_dec;
                    end
                    else
                    begin
                        bot_upd = '0;
                        top_upd = nz_reg ? top_reg + PW'(1) : '0;
                    end
                end
                else if (char_code == dsds_pkg::CH_DOT)
                begin
                    if (dot_reg)
                        fail_upd = 1'b1;
                    else
                        dot_upd = 1'b1;
                end
            end
        end
    end

    // summary of the string as it stands after this character
    always_comb
    begin
        fin_flags.ok        = !over_upd && !fail_upd && !(in_exp_upd && !exp_dig_upd)
                              && (nz_upd || zs_upd);
        fin_flags.has_digit = nz_upd;
        fin_flags.exp_neg   = exp_neg_upd;
        fin_exp             = exp_val_upd;
        fin_top             = top_upd;
        fin_bot             = bot_upd;
    end

    // clear after the string ends
    always_comb
    begin
        char_pos_next = item_ends ? '0 : char_pos_upd;
        over_next     = item_ends ? 1'b0 : over_upd;
        in_exp_next   = item_ends ? 1'b0 : in_exp_upd;
        exp_neg_next  = item_ends ? 1'b0 : exp_neg_upd;
        exp_val_next  = item_ends ? '0 : exp_val_upd;
        exp_dig_next  = item_ends ? 1'b0 : exp_dig_upd;
        exp_any_next  = item_ends ? 1'b0 : exp_any_upd;
        fail_next     = item_ends ? 1'b0 : fail_upd;
        dot_next      = item_ends ? 1'b0 : dot_upd;
        nz_next       = item_ends ? 1'b0 : nz_upd;
        zs_next       = item_ends ? 1'b0 : zs_upd;
        top_next      = item_ends ? '0 : top_upd;
        bot_next      = item_ends ? '0 : bot_upd;
        frac_next     = item_ends ? '0 : frac_upd;
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_pos_reg <= '0;
            over_reg     <= 1'b0;
            in_exp_reg   <= 1'b0;
            exp_neg_reg  <= 1'b0;
            exp_val_reg  <= '0;
            exp_dig_reg  <= 1'b0;
            exp_any_reg  <= 1'b0;
            fail_reg     <= 1'b0;
            dot_reg      <= 1'b0;
            nz_reg       <= 1'b0;
            zs_reg       <= 1'b0;
            top_reg      <= '0;
            bot_reg      <= '0;
            frac_reg     <= '0;
        end
        else if (take)
        begin
            char_pos_reg <= char_pos_next;
            over_reg     <= over_next;
            in_exp_reg   <= in_exp_next;
            exp_neg_reg  <= exp_neg_next;
            exp_val_reg  <= exp_val_next;
            exp_dig_reg  <= exp_dig_next;
            exp_any_reg  <= exp_any_next;
            fail_reg     <= fail_next;
            dot_reg      <= dot_next;
            nz_reg       <= nz_next;
            zs_reg       <= zs_next;
            top_reg      <= top_next;
            bot_reg      <= bot_next;
            frac_reg     <= frac_next;
        end
    end

endmodule

// ===== sv/decimal_significant_digit_span.sv =====
// ----------------------------------------------------------------------------
// decimal_significant_digit_span
// Parses a decimal number text one character per transfer and reports
// validity and the powers of ten of its largest and smallest significant
// digits when the string ends.
// ----------------------------------------------------------------------------
// path: a string end passes the input register, finished string register and result register
// throughput: one character per cycle; input register, parse stage and
//   result register each hold one item, so a waiting result does not stall
//   the characters behind it until both later stages are full
// reset: asynchronous, clears all pipeline valids and the parse state
module decimal_significant_digit_span #(
    parameter int MAX_CHARS      = 64,
    parameter int EXPONENT_LIMIT = 9999
) (
    input  logic       clk,
    input  logic       rst_n,
    dsds_char_if.sink  chars,
    dsds_res_if.source result
);

    localparam int EW = $clog2(EXPONENT_LIMIT + 1);
    localparam int PW = $clog2(MAX_CHARS + 1) + 1;
    localparam int SW = ((PW > EW + 1) ? PW : EW + 1) + 1;
    localparam int XW = (SW > int'(dsds_pkg::PLACE_W)) ? SW : int'(dsds_pkg::PLACE_W);

    // input register
    logic       in_v_reg, in_v_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;
    logic       in_empty_reg;

    // finished string register
    logic                 snap_v_reg, snap_v_next;
    dsds_pkg::fin_flags_t snap_flags_reg;
    logic [EW-1:0]        snap_exp_reg;
    logic signed [PW-1:0] snap_top_reg;
    logic signed [PW-1:0] snap_bot_reg;

    // result register
    logic                                out_v_reg, out_v_next;
    logic                                out_ok_reg;
    logic signed [dsds_pkg::PLACE_W-1:0] out_ld_reg;
    logic signed [dsds_pkg::PLACE_W-1:0] out_sd_reg;

    dsds_pkg::fin_flags_t fin_flags;
    logic [EW-1:0]        fin_exp;
    logic signed [PW-1:0] fin_top;
    logic signed [PW-1:0] fin_bot;

    logic out_free;
    logic snap_adv;
    logic item_ends;
    logic parse_adv;
    logic in_xfer;

    logic signed [XW-1:0] exp_x;
    logic signed [XW-1:0] ld_sum;
    logic signed [XW-1:0] sd_sum;

    // pipeline flow control
    assign out_free  = !out_v_reg || result.ready;
    assign snap_adv  = snap_v_reg && out_free;
    assign item_ends = in_empty_reg || in_last_reg;
    assign parse_adv = in_v_reg && (!item_ends || !snap_v_reg || out_free);
    assign chars.ready = !in_v_reg || parse_adv;
    assign in_xfer   = chars.valid && chars.ready;

    always_comb
    begin
        in_v_next   = in_xfer ? 1'b1 : (parse_adv ? 1'b0 : in_v_reg);
        snap_v_next = (parse_adv && item_ends) ? 1'b1 : (snap_adv ? 1'b0 : snap_v_reg);
        out_v_next  = snap_adv ? 1'b1 : (result.ready ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg   <= 1'b0;
            snap_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            in_v_reg   <= in_v_next;
            snap_v_reg <= snap_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_char_reg  <= chars.char_code;
            in_last_reg  <= chars.last_char;
            in_empty_reg <= chars.empty_string;
        end
    end

    // character parser
    dsds_parser #(
        .MAX_CHARS      (MAX_CHARS),
        .EXPONENT_LIMIT (EXPONENT_LIMIT),
        .EW             (EW),
        .PW             (PW)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (parse_adv),
        .char_code    (in_char_reg),
        .empty_string (in_empty_reg),
        .item_ends    (item_ends),
        .fin_flags    (fin_flags),
        .fin_exp      (fin_exp),
        .fin_top      (fin_top),
        .fin_bot      (fin_bot)
    );

    // capture the summary of a finished string
    always_ff @(posedge clk)
    begin
        if (parse_adv && item_ends)
        begin
            snap_flags_reg <= fin_flags;
            snap_exp_reg   <= fin_exp;
            snap_top_reg   <= fin_top;
            snap_bot_reg   <= fin_bot;
        end
    end

    // apply the signed exponent to both digit places
    always_comb
    begin
        exp_x  = XW'($signed({1'b0, snap_exp_reg}));
        ld_sum = snap_flags_reg.exp_neg ? XW'(snap_top_reg) - exp_x
                                        : XW'(snap_top_reg) + exp_x;
        sd_sum = snap_flags_reg.exp_neg ? XW'(snap_bot_reg) - exp_x
                                        : XW'(snap_bot_reg) + exp_x;
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            out_ok_reg <= snap_flags_reg.ok;
            if (snap_flags_reg.ok && snap_flags_reg.has_digit)
            begin
                out_ld_reg <= ld_sum[dsds_pkg::PLACE_W-1:0];
                out_sd_reg <= sd_sum[dsds_pkg::PLACE_W-1:0];
            end
            else
            begin
                out_ld_reg <= '0;
                out_sd_reg <= '0;
            end
        end
    end

    assign result.valid          = out_v_reg;
    assign result.valid_res      = out_ok_reg;
    assign result.largest_digit  = out_ld_reg;
    assign result.smallest_digit = out_sd_reg;

    // an invalid text reports zero places
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !out_ok_reg) |-> (out_ld_reg == '0 && out_sd_reg == '0))
        else $error("invalid result with nonzero digit places");

    // a finished string waits while the result register is blocked
    a_snap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (snap_v_reg && !out_free) |=> (snap_v_reg && $stable(snap_top_reg)
                                       && $stable(snap_bot_reg)))
        else $error("finished string lost under stall");

    // a summary only appears when a string ends
    a_snap_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!snap_v_reg && !(parse_adv && item_ends)) |=> !snap_v_reg)
        else $error("summary without a string end");

endmodule
